/* src/first_fit_block_allocator_assert.svh */
// Assertion macros for the first-fit block allocator.
// All of them sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define FFBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define FFBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FFBA_ASSERT(lbl, prop, msg)
`define FFBA_ASSERT_IMPLY(lbl, ante, cons, msg)
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/ffba_pkg.sv */
`default_nettype none

package ffba_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [31:0] HEAP_BASE_RESET = 32'h0100_0000;
    localparam logic [31:0] HEAP_SIZE_RESET = 32'h8000_0000;

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] size;
        logic        free;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } mem_rd_t;

endpackage

`default_nettype wire

/* src/first_fit_block_allocator.sv */
// Channel   Handshake                 Payload
// in        in_valid / in_ready       opcode, request_size, block_address
// out       out_valid / out_ready     granted_address, status, space_left
// cfg       cfg_write                 cfg_index, cfg_data
//
// An allocation of zero bytes or of more than the free bytes is rejected at once; every
// other item scans the table from entry 0, and in_ready stays low until its result is registered.
// The scan reads one table entry per cycle through the single memory read port, and
// an insert then moves one entry per cycle through the same port before two final writes.
// After reset and each configuration write, entry 0 is rewritten while in_ready is low.
// A finished result waits in the output register while the next transfer is accepted.
`default_nettype none

`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         in_valid,
    output logic        in_ready,
    input  wire         opcode,
    input  wire  [31:0] request_size,
    input  wire  [31:0] block_address,

    output logic        out_valid,
    input  wire         out_ready,
    output logic [31:0] granted_address,
    output logic [1:0]  status,
    output logic [31:0] space_left,

    input  wire         cfg_write,
    input  wire         cfg_index,
    input  wire  [31:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WR_HI,
        S_WR_LO,
        S_RESP
    } state_t;

    state_t           state_reg, state_next;
    logic             init_pending_reg, init_pending_next;
    logic [31:0]      heap_base_reg, heap_base_next;
    logic [31:0]      heap_size_reg, heap_size_next;
    logic [31:0]      free_bytes_reg, free_bytes_next;
    logic [CNT_W-1:0] count_reg, count_next;

    op_t              op_reg, op_next;
    logic [31:0]      size_reg, size_next;
    logic [31:0]      baddr_reg, baddr_next;

    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_v_reg, rd_v_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    entry_t           hit_entry_reg, hit_entry_next;
    logic [IDX_W-1:0] sh_idx_reg, sh_idx_next;
    logic [IDX_W-1:0] sh_wr_reg, sh_wr_next;
    logic             sh_v_reg, sh_v_next;

    logic [31:0]      res_granted_reg, res_granted_next;
    status_t          res_status_reg, res_status_next;

    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_granted_reg, out_granted_next;
    status_t          out_status_reg, out_status_next;
    logic [31:0]      out_space_reg, out_space_next;

    mem_wr_t          mem_wr;
    mem_rd_t          mem_rd;
    entry_t           rdata;
    logic             hit;

    ffba_table u_table (
        .clk   (clk),
        .wr    (mem_wr),
        .rd    (mem_rd),
        .rdata (rdata)
    );

    assign in_ready        = (state_reg == S_IDLE) && !init_pending_reg;
    assign out_valid       = out_valid_reg;
    assign granted_address = out_granted_reg;
    assign status          = out_status_reg;
    assign space_left      = out_space_reg;

    always_comb
    begin
        if (op_reg == OP_ALLOC)
        begin
            hit = rd_v_reg && rdata.free && (rdata.size >= size_reg);
        end
        else
        begin
            hit = rd_v_reg && !rdata.free && (rdata.addr == baddr_reg);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        init_pending_next = init_pending_reg;
        heap_base_next    = heap_base_reg;
        heap_size_next    = heap_size_reg;
        free_bytes_next   = free_bytes_reg;
        count_next        = count_reg;
        op_next           = op_reg;
        size_next         = size_reg;
        baddr_next        = baddr_reg;
        rd_idx_next       = rd_idx_reg;
        rd_v_next         = rd_v_reg;
        chk_idx_next      = chk_idx_reg;
        hit_idx_next      = hit_idx_reg;
        hit_entry_next    = hit_entry_reg;
        sh_idx_next       = sh_idx_reg;
        sh_wr_next        = sh_wr_reg;
        sh_v_next         = sh_v_reg;
        res_granted_next  = res_granted_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg;
        out_granted_next  = out_granted_reg;
        out_status_next   = out_status_reg;
        out_space_next    = out_space_reg;
        mem_wr            = '0;
        mem_rd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (init_pending_reg)
                begin
                    mem_wr.en         = 1'b1;
                    mem_wr.idx        = '0;
                    mem_wr.data       = '{addr: heap_base_reg, size: heap_size_reg, free: 1'b1};
                    free_bytes_next   = heap_size_reg;
                    count_next        = CNT_W'(1);
                    init_pending_next = 1'b0;
                end
                else if (in_valid)
                begin
                    op_next    = op_t'(opcode);
                    size_next  = request_size;
                    baddr_next = block_address;
                    if ((op_t'(opcode) == OP_ALLOC)
                        && ((request_size == 32'd0) || (request_size > free_bytes_reg)))
                    begin
                        res_granted_next = '0;
                        res_status_next  = ST_NOSPACE;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        rd_idx_next = '0;
                        rd_v_next   = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    rd_v_next      = 1'b0;
                    hit_idx_next   = chk_idx_reg;
                    hit_entry_next = rdata;
                    if (op_reg == OP_FREE)
                    begin
                        mem_wr.en        = 1'b1;
                        mem_wr.idx       = chk_idx_reg;
                        mem_wr.data      = '{addr: rdata.addr, size: rdata.size, free: 1'b1};
                        free_bytes_next  = free_bytes_reg + rdata.size;
                        res_granted_next = '0;
                        res_status_next  = ST_OK;
                        state_next       = S_RESP;
                    end
                    else if (count_reg == CNT_W'(MAX_ENTRIES))
                    begin
                        res_granted_next = '0;
                        res_status_next  = ST_FULL;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        sh_idx_next = IDX_W'(count_reg - CNT_W'(1));
                        sh_v_next   = 1'b0;
                        state_next  = S_SHIFT;
                    end
                end
                else if (!rd_v_reg && (rd_idx_reg == count_reg))
                begin
                    res_granted_next = '0;
                    res_status_next  = (op_reg == OP_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
                    state_next       = S_RESP;
                end
                else
                begin
                    rd_v_next = rd_idx_reg < count_reg;
                    if (rd_idx_reg < count_reg)
                    begin
                        mem_rd.en    = 1'b1;
                        mem_rd.idx   = rd_idx_reg[IDX_W-1:0];
                        chk_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    end
                end
            end

            S_SHIFT:
            begin
                if (sh_v_reg)
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.idx  = sh_wr_reg;
                    mem_wr.data = rdata;
                end
                if (sh_idx_reg > hit_idx_reg)
                begin
                    mem_rd.en   = 1'b1;
                    mem_rd.idx  = sh_idx_reg;
                    sh_wr_next  = sh_idx_reg + IDX_W'(1);
                    sh_idx_next = sh_idx_reg - IDX_W'(1);
                    sh_v_next   = 1'b1;
                end
                else
                begin
                    sh_v_next = 1'b0;
                    if (!sh_v_reg)
                    begin
                        state_next = S_WR_HI;
                    end
                end
            end

            S_WR_HI:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.idx  = hit_idx_reg + IDX_W'(1);
                mem_wr.data = '{addr: hit_entry_reg.addr + size_reg,
                                size: hit_entry_reg.size - size_reg,
                                free: 1'b1};
                state_next  = S_WR_LO;
            end

            S_WR_LO:
            begin
                mem_wr.en        = 1'b1;
                mem_wr.idx       = hit_idx_reg;
                mem_wr.data      = '{addr: hit_entry_reg.addr, size: size_reg, free: 1'b0};
                count_next       = count_reg + CNT_W'(1);
                free_bytes_next  = free_bytes_reg - size_reg;
                res_granted_next = hit_entry_reg.addr;
                res_status_next  = ST_OK;
                state_next       = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_status_next  = res_status_reg;
                    out_space_next   = free_bytes_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            if (cfg_index == CFG_HEAP_BASE)
            begin
                heap_base_next = cfg_data;
            end
            else
            begin
                heap_size_next = cfg_data;
            end
            init_pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            init_pending_reg <= 1'b1;
            heap_base_reg    <= HEAP_BASE_RESET;
            heap_size_reg    <= HEAP_SIZE_RESET;
            free_bytes_reg   <= HEAP_SIZE_RESET;
            count_reg        <= CNT_W'(1);
            op_reg           <= OP_ALLOC;
            size_reg         <= '0;
            baddr_reg        <= '0;
            rd_idx_reg       <= '0;
            rd_v_reg         <= 1'b0;
            chk_idx_reg      <= '0;
            hit_idx_reg      <= '0;
            hit_entry_reg    <= '0;
            sh_idx_reg       <= '0;
            sh_wr_reg        <= '0;
            sh_v_reg         <= 1'b0;
            res_granted_reg  <= '0;
            res_status_reg   <= ST_OK;
            out_valid_reg    <= 1'b0;
            out_granted_reg  <= '0;
            out_status_reg   <= ST_OK;
            out_space_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            init_pending_reg <= init_pending_next;
            heap_base_reg    <= heap_base_next;
            heap_size_reg    <= heap_size_next;
            free_bytes_reg   <= free_bytes_next;
            count_reg        <= count_next;
            op_reg           <= op_next;
            size_reg         <= size_next;
            baddr_reg        <= baddr_next;
            rd_idx_reg       <= rd_idx_next;
            rd_v_reg         <= rd_v_next;
            chk_idx_reg      <= chk_idx_next;
            hit_idx_reg      <= hit_idx_next;
            hit_entry_reg    <= hit_entry_next;
            sh_idx_reg       <= sh_idx_next;
            sh_wr_reg        <= sh_wr_next;
            sh_v_reg         <= sh_v_next;
            res_granted_reg  <= res_granted_next;
            res_status_reg   <= res_status_next;
            out_valid_reg    <= out_valid_next;
            out_granted_reg  <= out_granted_next;
            out_status_reg   <= out_status_next;
            out_space_reg    <= out_space_next;
        end
    end

    `FFBA_ASSERT(a_count_range, (count_reg != '0) && (count_reg <= CNT_W'(MAX_ENTRIES)), "Entry count out of range.")
    `FFBA_ASSERT_IMPLY(a_free_bounded, !init_pending_reg, free_bytes_reg <= heap_size_reg, "Free bytes exceed the heap size.")
    `FFBA_ASSERT_IMPLY(a_shift_above_hit, (state_reg == S_SHIFT) && mem_wr.en, mem_wr.idx > hit_idx_reg, "Shift writes at or below the insert point.")
    `FFBA_ASSERT_IMPLY(a_scan_in_table, (state_reg == S_SCAN) && mem_rd.en, rd_idx_reg < count_reg, "Scan reads past the last entry.")
    `FFBA_ASSERT_NEXT(a_insert_count, state_reg == S_WR_LO, count_reg == $past(count_reg) + CNT_W'(1), "Insert did not grow the table.")

endmodule

`default_nettype wire

/* src/ffba_table.sv */
`default_nettype none

module ffba_table
    import ffba_pkg::*;
(
    input  wire          clk,
    input  wire mem_wr_t wr,
    input  wire mem_rd_t rd,
    output entry_t       rdata
);

    entry_t mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (rd.en)
        begin
            rdata <= mem[rd.idx];
        end
    end

endmodule

`default_nettype wire
